>>> rtl/mcs_pkg.sv
`default_nettype none

package mcs_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_EXEC = 2'd1,
        MODE_COOL = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DRV_OFF = 2'd0,
        DRV_FWD = 2'd1,
        DRV_REV = 2'd2
    } drive_t;

    localparam logic [7:0] DIR_FWD   = 8'h46;  // 'F'
    localparam logic [7:0] DIR_BACK  = 8'h42;  // 'B'
    localparam logic [7:0] DIR_RIGHT = 8'h52;  // 'R'
    localparam logic [7:0] DIR_LEFT  = 8'h4C;  // 'L'
    localparam logic [7:0] DIR_STOP  = 8'h53;  // 'S'

    localparam logic [15:0] COOLDOWN_RESET = 16'd2;
    localparam logic [15:0] MIN_MOVE_RESET = 16'd1;

    // register index, taken from paddr[2]
    localparam logic REG_COOLDOWN = 1'b0;
    localparam logic REG_MIN_MOVE = 1'b1;

    typedef struct packed {
        logic [15:0] cooldown_ticks;
        logic [15:0] min_move_ticks;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [7:0]  move_dir;
        logic [15:0] move_ticks;
        logic [15:0] now;
    } item_t;

    typedef struct packed {
        logic   pending;
        mode_t  mode_now;
        drive_t right_drive;
        drive_t left_drive;
    } result_t;

    function automatic logic known_dir(input logic [7:0] d);
        return (d == DIR_FWD) || (d == DIR_BACK) || (d == DIR_RIGHT) || (d == DIR_LEFT);
    endfunction

    function automatic logic [15:0] clamp_ticks(input logic [15:0] ticks,
                                                input logic [15:0] min_ticks);
        return (ticks < min_ticks) ? min_ticks : ticks;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mcs_apb_regs.sv
`default_nettype none

module mcs_apb_regs
    import mcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [15:0] cooldown_reg;
    logic [15:0] min_move_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cooldown_reg <= COOLDOWN_RESET;
            min_move_reg <= MIN_MOVE_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_COOLDOWN: cooldown_reg <= pwdata[15:0];
                REG_MIN_MOVE: min_move_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_COOLDOWN: prdata = {16'd0, cooldown_reg};
            REG_MIN_MOVE: prdata = {16'd0, min_move_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.cooldown_ticks = cooldown_reg;
    assign cfg.min_move_ticks = min_move_reg;

endmodule

`default_nettype wire

>>> rtl/mcs_pass_engine.sv
`default_nettype none

module mcs_pass_engine
    import mcs_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  fire,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;

    mode_t                mode_reg,         mode_next;
    logic [TIME_BITS-1:0] move_start_reg,   move_start_next;
    logic [15:0]          move_length_reg,  move_length_next;
    logic [7:0]           active_dir_reg,   active_dir_next;
    logic [7:0]           queued_dir_reg,   queued_dir_next;
    logic [15:0]          queued_ticks_reg, queued_ticks_next;
    logic                 queued_valid_reg, queued_valid_next;
    logic [TIME_BITS-1:0] pause_start_reg,  pause_start_next;

    logic [TIME_BITS-1:0] tnow;
    logic [TIME_BITS-1:0] move_age;
    logic [TIME_BITS-1:0] pause_age;
    logic                 was_exec;

    always_comb begin
        tnow              = TIME_BITS'(item.now);
        mode_next         = mode_reg;
        move_start_next   = move_start_reg;
        move_length_next  = move_length_reg;
        active_dir_next   = active_dir_reg;
        queued_dir_next   = queued_dir_reg;
        queued_ticks_next = queued_ticks_reg;
        queued_valid_next = queued_valid_reg;
        pause_start_next  = pause_start_reg;
        was_exec          = (mode_reg == MODE_EXEC);

        // command
        if (item.action) begin
            if (item.move_dir == DIR_STOP) begin
                queued_valid_next = 1'b0;
                mode_next         = MODE_IDLE;
                move_length_next  = 16'd0;
                active_dir_next   = 8'd0;
                if (was_exec) begin
                    pause_start_next = tnow;
                    mode_next        = MODE_COOL;
                end
            end else if (item.move_ticks != 16'd0) begin
                if (mode_reg == MODE_EXEC && item.move_dir != active_dir_reg) begin
                    queued_dir_next   = item.move_dir;
                    queued_ticks_next = item.move_ticks;
                    queued_valid_next = 1'b1;
                    move_length_next  = 16'd0;
                    active_dir_next   = 8'd0;
                    pause_start_next  = tnow;
                    mode_next         = MODE_COOL;
                end else if (mode_reg == MODE_COOL) begin
                    queued_dir_next   = item.move_dir;
                    queued_ticks_next = item.move_ticks;
                    queued_valid_next = 1'b1;
                end else begin
                    mode_next         = MODE_EXEC;
                    move_start_next   = tnow;
                    move_length_next  = clamp_ticks(item.move_ticks, cfg.min_move_ticks);
                    active_dir_next   = item.move_dir;
                    queued_valid_next = 1'b0;
                    if (!known_dir(item.move_dir)) begin
                        mode_next        = MODE_IDLE;
                        move_length_next = 16'd0;
                        active_dir_next  = 8'd0;
                    end
                end
            end
        end

        // move timeout
        move_age = TIME_BITS'(tnow - move_start_next);
        if (mode_next == MODE_EXEC && CW'(move_age) >= CW'(move_length_next)) begin
            mode_next        = MODE_IDLE;
            move_length_next = 16'd0;
            active_dir_next  = 8'd0;
            if (queued_valid_next) begin
                pause_start_next = tnow;
                mode_next        = MODE_COOL;
            end
        end

        // cooldown end, then any queued move starts
        pause_age = TIME_BITS'(tnow - pause_start_next);
        if (mode_next == MODE_COOL && CW'(pause_age) >= CW'(cfg.cooldown_ticks)) begin
            mode_next = MODE_IDLE;
            if (queued_valid_next) begin
                queued_valid_next = 1'b0;
                mode_next         = MODE_EXEC;
                move_start_next   = tnow;
                move_length_next  = clamp_ticks(queued_ticks_next, cfg.min_move_ticks);
                active_dir_next   = queued_dir_next;
                if (!known_dir(queued_dir_next)) begin
                    mode_next        = MODE_IDLE;
                    move_length_next = 16'd0;
                    active_dir_next  = 8'd0;
                end
            end
        end
    end

    always_comb begin
        result.left_drive  = DRV_OFF;
        result.right_drive = DRV_OFF;
        if (mode_next == MODE_EXEC) begin
            unique case (active_dir_next)
                DIR_FWD: begin
                    result.left_drive  = DRV_FWD;
                    result.right_drive = DRV_FWD;
                end
                DIR_BACK: begin
                    result.left_drive  = DRV_REV;
                    result.right_drive = DRV_REV;
                end
                DIR_RIGHT: begin
                    result.left_drive  = DRV_FWD;
                    result.right_drive = DRV_REV;
                end
                DIR_LEFT: begin
                    result.left_drive  = DRV_REV;
                    result.right_drive = DRV_FWD;
                end
                default: ;
            endcase
        end
        result.mode_now = mode_next;
        result.pending  = queued_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_IDLE;
            move_start_reg   <= '0;
            move_length_reg  <= '0;
            active_dir_reg   <= '0;
            queued_dir_reg   <= '0;
            queued_ticks_reg <= '0;
            queued_valid_reg <= 1'b0;
            pause_start_reg  <= '0;
        end else if (fire) begin
            mode_reg         <= mode_next;
            move_start_reg   <= move_start_next;
            move_length_reg  <= move_length_next;
            active_dir_reg   <= active_dir_next;
            queued_dir_reg   <= queued_dir_next;
            queued_ticks_reg <= queued_ticks_next;
            queued_valid_reg <= queued_valid_next;
            pause_start_reg  <= pause_start_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/motion_command_sequencer_core.sv
`default_nettype none
// Channel   Dir  Handshake         Payload
// s_*       in   s_tvalid/tready   tdata: move_dir, move_ticks, now; tuser: action
// m_*       out  m_tvalid/tready   tdata: left_drive, right_drive, mode_now, pending
// apb       in   psel/penable      cooldown_ticks @0x0, min_move_ticks @0x4
//
// One transfer per cycle sustained while m_tready is high; an item goes from the
// input register to the result register. The pass engine updates its state in
// the cycle the input register hands its item to the result register. Reset is
// synchronous, active low, and clears the state, config registers and both valid flags.
// A stall on m_tready backs up through both registers to s_tready.

module motion_command_sequencer_core
    import mcs_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // move_dir[7:0], move_ticks[23:8], now[39:24]
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // left_drive[1:0], right_drive[3:2], mode_now[5:4],
                                        // pending[6], zero[7]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result;
    logic [7:0] out_data_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    mcs_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcs_pass_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.action     <= s_tuser;
            item_reg.move_dir   <= s_tdata[7:0];
            item_reg.move_ticks <= s_tdata[23:8];
            item_reg.now        <= s_tdata[39:24];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {1'b0, result};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
